/* sv/pscm_pkg.sv */
package pscm_pkg;

    // Field widths
    localparam int TIME_W   = 32;   // timestamp bits used for hold-off arithmetic
    localparam int LEVEL_W  = 8;
    localparam int SPEED_W  = 10;
    localparam int HOLD_W   = 16;
    localparam int DECAY_W  = 4;
    localparam int NOW_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    // Fixed-point reciprocal for level / 5: floor(x * 205 / 1024) for any 8-bit x
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_CLUTCH_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_THR    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THR       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_HOLDOFF    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_HOLDOFF   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_STEP     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD    = 8'd7;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] RST_MODE_CLUTCH_THR = 8'd14;
    localparam logic [LEVEL_W-1:0] RST_THROTTLE_THR    = 8'd13;
    localparam logic [LEVEL_W-1:0] RST_BRAKE_THR       = 8'd30;
    localparam logic [HOLD_W-1:0]  RST_MODE_HOLDOFF    = 16'd1000;
    localparam logic [HOLD_W-1:0]  RST_BRAKE_HOLDOFF   = 16'd500;
    localparam logic [SPEED_W-1:0] RST_SPEED_MAX       = 10'd300;
    localparam logic [LEVEL_W-1:0] RST_STATIC_STEP     = 8'd20;
    localparam logic [DECAY_W-1:0] RST_DECAY_PERIOD    = 4'd10;

    // Drive modes
    localparam logic MODE_STATIC  = 1'b0;
    localparam logic MODE_DYNAMIC = 1'b1;

    typedef struct packed {
        logic [LEVEL_W-1:0] mode_clutch_thr;
        logic [LEVEL_W-1:0] throttle_thr;
        logic [LEVEL_W-1:0] brake_thr;
        logic [HOLD_W-1:0]  mode_holdoff;
        logic [HOLD_W-1:0]  brake_holdoff;
        logic [SPEED_W-1:0] speed_max;
        logic [LEVEL_W-1:0] static_step;
        logic [DECAY_W-1:0] decay_period;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] throttle;
        logic [LEVEL_W-1:0] brake;
        logic [LEVEL_W-1:0] clutch;
        logic [NOW_W-1:0]   now_ms;
    } t_report;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               mode;
        logic               throttle_counted;
        logic               brake_counted;
        logic [TIME_W-1:0]  last_toggle;
        logic [TIME_W-1:0]  last_brake;
        logic [DECAY_W-1:0] decay_cnt;
        logic [LEVEL_W-1:0] held_throttle;
        logic [LEVEL_W-1:0] held_brake;
        logic               clutch_flag;
    } t_state;

endpackage

/* sv/pscm_cfg_regs.sv */
module pscm_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pscm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pscm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pscm_pkg::t_cfg                     o_cfg
);

    pscm_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_clutch_thr <= pscm_pkg::RST_MODE_CLUTCH_THR;
            r_cfg.throttle_thr    <= pscm_pkg::RST_THROTTLE_THR;
            r_cfg.brake_thr       <= pscm_pkg::RST_BRAKE_THR;
            r_cfg.mode_holdoff    <= pscm_pkg::RST_MODE_HOLDOFF;
            r_cfg.brake_holdoff   <= pscm_pkg::RST_BRAKE_HOLDOFF;
            r_cfg.speed_max       <= pscm_pkg::RST_SPEED_MAX;
            r_cfg.static_step     <= pscm_pkg::RST_STATIC_STEP;
            r_cfg.decay_period    <= pscm_pkg::RST_DECAY_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pscm_pkg::CFG_MODE_CLUTCH_THR:
                    r_cfg.mode_clutch_thr <= i_cfg_data[pscm_pkg::LEVEL_W-1:0];
                pscm_pkg::CFG_THROTTLE_THR:
                    r_cfg.throttle_thr <= i_cfg_data[pscm_pkg::LEVEL_W-1:0];
                pscm_pkg::CFG_BRAKE_THR:
                    r_cfg.brake_thr <= i_cfg_data[pscm_pkg::LEVEL_W-1:0];
                pscm_pkg::CFG_MODE_HOLDOFF:
                    r_cfg.mode_holdoff <= i_cfg_data[pscm_pkg::HOLD_W-1:0];
                pscm_pkg::CFG_BRAKE_HOLDOFF:
                    r_cfg.brake_holdoff <= i_cfg_data[pscm_pkg::HOLD_W-1:0];
                pscm_pkg::CFG_SPEED_MAX:
                    r_cfg.speed_max <= i_cfg_data[pscm_pkg::SPEED_W-1:0];
                pscm_pkg::CFG_STATIC_STEP:
                    r_cfg.static_step <= i_cfg_data[pscm_pkg::LEVEL_W-1:0];
                pscm_pkg::CFG_DECAY_PERIOD:
                    r_cfg.decay_period <= i_cfg_data[pscm_pkg::DECAY_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* sv/pscm_update.sv */
module pscm_update (
    input  pscm_pkg::t_cfg    i_cfg,
    input  pscm_pkg::t_report i_report,
    input  pscm_pkg::t_state  i_state,
    output pscm_pkg::t_state  o_state
);

    localparam int SUM_W = pscm_pkg::SPEED_W + 1;

    // Increase, saturating at speed_max
    function automatic logic [SUM_W-1:0] clamp_up(
        input logic [SUM_W-1:0]             v,
        input logic [pscm_pkg::SPEED_W-1:0] vmax
    );
        logic [SUM_W-1:0] m;
        m = {1'b0, vmax};
        return (v > m) ? m : v;
    endfunction

    // Decrease, flooring at zero
    function automatic logic [SUM_W-1:0] sub_floor(
        input logic [SUM_W-1:0] v,
        input logic [SUM_W-1:0] d
    );
        return (d >= v) ? '0 : (v - d);
    endfunction

    logic [SUM_W-1:0]                   spd;
    logic [pscm_pkg::TIME_W-1:0]        now_t;
    logic [pscm_pkg::TIME_W-1:0]        el_tog;
    logic [pscm_pkg::TIME_W-1:0]        el_brk;
    logic [15:0]                        prod;
    logic [pscm_pkg::LEVEL_W-1:0]       thr_div5;
    logic [pscm_pkg::DECAY_W:0]         cnt_nxt;
    pscm_pkg::t_state                   n_st;

    always_comb begin
        n_st     = i_state;
        now_t    = i_report.now_ms[pscm_pkg::TIME_W-1:0];
        el_tog   = now_t - i_state.last_toggle;
        el_brk   = now_t - i_state.last_brake;
        prod     = 16'(i_report.throttle) * 16'(pscm_pkg::DIV5_MUL);
        thr_div5 = pscm_pkg::LEVEL_W'(prod >> pscm_pkg::DIV5_SHIFT);
        spd      = {1'b0, i_state.speed};
        cnt_nxt  = {1'b0, i_state.decay_cnt} + 1'b1;

        // Clutch: mode toggle with hold-off, entering static clears speed
        if (i_report.clutch != '0) begin
            n_st.clutch_flag = 1'b1;
            if (i_report.clutch > i_cfg.mode_clutch_thr &&
                el_tog > pscm_pkg::TIME_W'(i_cfg.mode_holdoff)) begin
                if (i_state.mode == pscm_pkg::MODE_STATIC) begin
                    n_st.mode = pscm_pkg::MODE_DYNAMIC;
                end else begin
                    n_st.mode = pscm_pkg::MODE_STATIC;
                    spd       = '0;
                end
                n_st.last_toggle = now_t;
            end
        end else begin
            n_st.clutch_flag = 1'b0;
        end

        // Throttle
        if (i_report.throttle != '0) begin
            n_st.held_throttle = i_report.throttle;
            if (n_st.mode == pscm_pkg::MODE_STATIC) begin
                if (i_report.throttle > i_cfg.throttle_thr) begin
                    if (!i_state.throttle_counted) begin
                        spd = clamp_up(spd + SUM_W'(i_cfg.static_step), i_cfg.speed_max);
                    end
                    n_st.throttle_counted = 1'b1;
                end
            end else begin
                if (spd < {1'b0, i_cfg.speed_max}) begin
                    spd = clamp_up(spd + SUM_W'(thr_div5), i_cfg.speed_max);
                end
                // lightest touch still moves the speed
                if (i_report.throttle < 8'd2) begin
                    spd = clamp_up(spd + 1'b1, i_cfg.speed_max);
                end
            end
        end else begin
            n_st.throttle_counted = 1'b0;
        end

        // Brake with hold-off
        if (i_report.brake != '0) begin
            n_st.held_brake = i_report.brake;
            if (i_report.brake > i_cfg.brake_thr &&
                el_brk > pscm_pkg::TIME_W'(i_cfg.brake_holdoff)) begin
                if (n_st.mode == pscm_pkg::MODE_STATIC) begin
                    if (!i_state.brake_counted) begin
                        spd = sub_floor(spd, SUM_W'(i_cfg.static_step));
                    end
                    n_st.brake_counted = 1'b1;
                end else begin
                    spd = sub_floor(spd, SUM_W'({i_report.brake, 1'b0}));
                end
                n_st.last_brake = now_t;
            end
        end else begin
            n_st.brake_counted = 1'b0;
        end

        // Periodic decay in dynamic mode
        if (n_st.mode == pscm_pkg::MODE_DYNAMIC) begin
            if (cnt_nxt >= {1'b0, i_cfg.decay_period}) begin
                spd            = sub_floor(spd, SUM_W'(1));
                n_st.decay_cnt = '0;
            end else begin
                n_st.decay_cnt = cnt_nxt[pscm_pkg::DECAY_W-1:0];
            end
        end

        n_st.speed = spd[pscm_pkg::SPEED_W-1:0];
    end

    assign o_state = n_st;

endmodule

/* sv/pedal_speed_mode_controller_top.sv */
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   i_s_tdata: pedal report
// m         out        o_m_tvalid / i_m_tready   o_m_tdata: speed, mode, held levels
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One report per cycle unless the result stalls; a result passes through the input
// register, then the state register that also serves as the result register.
// The state update is a single combinational pass between those two registers.
// Synchronous active-low reset clears all state and restores register defaults.
// A stalled result holds the update; one more report may wait in the input register.
module pedal_speed_mode_controller_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // [7:0] throttle_in, [15:8] brake_in, [23:16] clutch_in, [55:24] now_ms
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [pscm_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [9:0] speed, [10] drive_mode, [18:11] throttle_level, [26:19] brake_level,
    // [27] clutch_pressed, [31:28] zero
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [pscm_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pscm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pscm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    pscm_pkg::t_cfg    cfg;
    pscm_pkg::t_report r_in;
    pscm_pkg::t_state  r_state;
    pscm_pkg::t_state  n_state;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;

    // Configuration registers
    pscm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: update when a report waits and the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.throttle <= i_s_tdata[7:0];
            r_in.brake    <= i_s_tdata[15:8];
            r_in.clutch   <= i_s_tdata[23:16];
            r_in.now_ms   <= i_s_tdata[55:24];
        end
    end

    // Next-state logic
    pscm_update u_update (
        .i_cfg    (cfg),
        .i_report (r_in),
        .i_state  (r_state),
        .o_state  (n_state)
    );

    // Controller state, doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_state.clutch_flag, r_state.held_brake,
                         r_state.held_throttle, r_state.mode, r_state.speed};

    // Decay counter never reaches the all-ones code
    a_decay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.decay_cnt != 4'hF)
        else $error("decay counter out of range");

    // Input side only stalls behind a waiting report and a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without cause");

    // Every update produces a result
    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_tvalid)
        else $error("update without result");

    // Speed only moves on an update
    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state.speed))
        else $error("speed changed without an update");

endmodule
